### design/tick_gap_filler_core_assert.svh
// Assertion macros shared by the verification files of the tick gap filler.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef TICK_GAP_FILLER_CORE_ASSERT_SVH
`define TICK_GAP_FILLER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tick gap filler check failed");

// The consequent must hold in the cycle after the antecedent.
`define TGF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tick gap filler check failed");

`endif

### design/tgf_pkg.sv
// Shared widths, register indexes and control structs of the tick gap filler.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none
package tgf_pkg;

    localparam int TIME_W       = 62;
    localparam int GRID_W       = 63;
    localparam int IVAL_W       = 52;
    localparam int PRICE_W      = 32;
    localparam int SIZE_W       = 32;
    localparam int FIELDS_W     = TIME_W + 3 * PRICE_W + 2 * SIZE_W;
    localparam int DATA_W       = ((FIELDS_W + 7) / 8) * 8;
    localparam int PAD_W        = DATA_W - FIELDS_W;
    localparam int USER_W       = 2;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 62;

    localparam int MAX_GHOSTS_DEF = 63;
    localparam int PRICE_BITS_DEF = 32;

    localparam logic [CFG_IDX_W-1:0] REG_START_TIME    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_INTERVAL = 1'b1;

    localparam int USER_GHOST = 0;
    localparam int USER_CAP   = 1;

    typedef struct packed {
        logic load_tick;
        logic emit_ghost;
        logic emit_real;
    } tgf_cmd_t;

    typedef struct packed {
        logic out_free;
        logic ghost_due;
    } tgf_stat_t;

endpackage
`default_nettype wire

### design/tgf_dp.sv
// Datapath of the tick gap filler: tick register, grid time, previous prices,
// ghost counter and the output register. Depends on tgf_pkg.
`default_nettype none
module tgf_dp
    import tgf_pkg::*;
#(
    parameter int MAX_GHOSTS = MAX_GHOSTS_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [DATA_W-1:0]     s_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire tgf_cmd_t              cmd,
    output tgf_stat_t                  stat,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [DATA_W-1:0]          m_tdata,
    output logic [USER_W-1:0]          m_tuser,
    output logic                       m_tlast
);

    localparam int KEEP_BITS = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
    localparam int CNT_BITS  = $clog2(MAX_GHOSTS + 1);

    logic [TIME_W-1:0]    time_reg;
    logic [KEEP_BITS-1:0] ask_reg, bid_reg, last_reg;
    logic [SIZE_W-1:0]    ask_size_reg, bid_size_reg;
    logic [KEEP_BITS-1:0] prev_ask_reg, prev_bid_reg, prev_last_reg;
    logic                 have_prev_reg;
    logic [GRID_W-1:0]    grid_reg, grid_next;
    logic [IVAL_W-1:0]    ival_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic                 out_valid_reg;
    logic [DATA_W-1:0]    out_data_reg, out_data_next;
    logic [USER_W-1:0]    out_user_reg, out_user_next;
    logic                 out_last_reg, out_last_next;
    logic [GRID_W:0]      grid_sum;
    logic                 gap;
    logic                 cap_reached;

    assign grid_sum    = {1'b0, grid_reg} + {{(GRID_W + 1 - IVAL_W){1'b0}}, ival_reg};
    assign gap         = {1'b0, time_reg} > grid_reg;
    assign cap_reached = (cnt_reg == CNT_BITS'(MAX_GHOSTS));

    assign stat.out_free  = !out_valid_reg || m_tready;
    assign stat.ghost_due = have_prev_reg && gap && !cap_reached;

    always_comb
    begin
        grid_next = grid_reg;
        if (cfg_we && cfg_index == REG_START_TIME)
        begin
            grid_next = {1'b0, cfg_data[TIME_W-1:0]};
        end
        else if (cmd.emit_ghost)
        begin
            grid_next = grid_sum[GRID_W] ? {GRID_W{1'b1}} : grid_sum[GRID_W-1:0];
        end
    end

    always_comb
    begin
        if (cmd.emit_ghost)
        begin
            out_data_next = {{PAD_W{1'b0}}, {SIZE_W{1'b0}}, {SIZE_W{1'b0}},
                             PRICE_W'(prev_last_reg), PRICE_W'(prev_bid_reg),
                             PRICE_W'(prev_ask_reg), grid_reg[TIME_W-1:0]};
            out_user_next = USER_W'(1) << USER_GHOST;
            out_last_next = 1'b0;
        end
        else
        begin
            out_data_next = {{PAD_W{1'b0}}, bid_size_reg, ask_size_reg,
                             PRICE_W'(last_reg), PRICE_W'(bid_reg),
                             PRICE_W'(ask_reg), time_reg};
            out_user_next = cap_reached ? (USER_W'(1) << USER_CAP) : '0;
            out_last_next = (cnt_reg != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            grid_reg      <= '0;
            ival_reg      <= {IVAL_W{1'b1}};
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            prev_ask_reg  <= '0;
            prev_bid_reg  <= '0;
            prev_last_reg <= '0;
        end
        else
        begin
            grid_reg <= grid_next;
            if (cfg_we && cfg_index == REG_GRID_INTERVAL)
            begin
                ival_reg <= cfg_data[IVAL_W-1:0];
            end
            if (cmd.load_tick)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.emit_ghost)
            begin
                cnt_reg <= CNT_BITS'(cnt_reg + 1'b1);
            end
            if (cmd.emit_real)
            begin
                have_prev_reg <= 1'b1;
                prev_ask_reg  <= ask_reg;
                prev_bid_reg  <= bid_reg;
                prev_last_reg <= last_reg;
            end
            if (cmd.emit_ghost || cmd.emit_real)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_tick)
        begin
            time_reg     <= s_tdata[TIME_W-1:0];
            ask_reg      <= s_tdata[TIME_W +: KEEP_BITS];
            bid_reg      <= s_tdata[TIME_W + PRICE_W +: KEEP_BITS];
            last_reg     <= s_tdata[TIME_W + 2 * PRICE_W +: KEEP_BITS];
            ask_size_reg <= s_tdata[TIME_W + 3 * PRICE_W +: SIZE_W];
            bid_size_reg <= s_tdata[TIME_W + 3 * PRICE_W + SIZE_W +: SIZE_W];
        end
        if (cmd.emit_ghost || cmd.emit_real)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

### design/tgf_ctrl.sv
// Controller of the tick gap filler: accepts one tick, then emits ghosts and
// the real tick one per free output slot. Depends on tgf_pkg.
`default_nettype none
module tgf_ctrl
    import tgf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire tgf_stat_t stat,
    output tgf_cmd_t       cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd.load_tick  = 1'b0;
        cmd.emit_ghost = 1'b0;
        cmd.emit_real  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_tick = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    if (stat.ghost_due)
                    begin
                        cmd.emit_ghost = 1'b1;
                    end
                    else
                    begin
                        cmd.emit_real = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

### design/tick_gap_filler_core.sv
// Tick gap filler: one tick in, its ghost ticks and the tick itself out.
// A tick sends its n ghosts, if any, and then itself. The next tick can be accepted
// once the tick itself has been loaded into the output register.
// The first result follows the tick load; one result per cycle while not stalled.
// The output register sets the pace: each result occupies it until it is taken.
// Reset clears the control state, the grid time to zero and the interval to its maximum.
`default_nettype none
module tick_gap_filler_core
    import tgf_pkg::*;
#(
    parameter int MAX_GHOSTS = MAX_GHOSTS_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // tick_time, ask_price, bid_price, last_trade_price, ask_size, bid_size, zero pad.
    input  wire logic [DATA_W-1:0]     s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // out_time, out_ask, out_bid, out_last_price, out_ask_size, out_bid_size, zero pad.
    output logic [DATA_W-1:0]          m_tdata,
    // is_ghost, cap_hit.
    output logic [USER_W-1:0]          m_tuser,
    output logic                       m_tlast,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    tgf_cmd_t  cmd;
    tgf_stat_t stat;

    assign cfg_ready = 1'b1;

    tgf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tgf_dp #(
        .MAX_GHOSTS (MAX_GHOSTS),
        .PRICE_BITS (PRICE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

### design/tgf_checker.sv
// Port-level checks of the tick gap filler, bound to the top level.
// Depends on tgf_pkg and tick_gap_filler_core_assert.svh.
`default_nettype none
`include "tick_gap_filler_core_assert.svh"
module tgf_port_checks
    import tgf_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [DATA_W-1:0] m_tdata,
    input wire logic [USER_W-1:0] m_tuser,
    input wire logic              m_tlast
);

    localparam int SIZES_LO = TIME_W + 3 * PRICE_W;

    logic [DATA_W+USER_W:0] out_word;
    logic                   ghost_out;

    assign out_word  = {m_tdata, m_tuser, m_tlast};
    assign ghost_out = m_tvalid && m_tuser[USER_GHOST];

    `TGF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(out_word))
    `TGF_ASSERT_SAME(a_ghost_flags, ghost_out, !m_tlast && !m_tuser[USER_CAP])
    `TGF_ASSERT_SAME(a_ghost_sizes, ghost_out, m_tdata[SIZES_LO +: 2 * SIZE_W] == '0)
    `TGF_ASSERT_SAME(a_cap_ends_run, m_tvalid && m_tuser[USER_CAP], m_tlast)
    `TGF_ASSERT_NEXT(a_one_tick, s_tvalid && s_tready, !s_tready)

endmodule

bind tick_gap_filler_core tgf_port_checks u_tgf_checker (.*);
`default_nettype wire

### dv/tgf_checker.sv
`timescale 1ns / 100ps
// Transaction checker for the tick gap filler: watches the tick, result and register channels,
// predicts the ghost and real ticks for every accepted tick and compares them in order.
// Depends on tgf_pkg for widths, register indexes and tuser bit positions.
module tgf_checker
    import tgf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [DATA_W-1:0]     s_tdata,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [DATA_W-1:0]     m_tdata,
    input  wire logic [USER_W-1:0]     m_tuser,
    input  wire logic                  m_tlast,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         mismatches,
    output int                         outstanding,
    output logic [GRID_W-1:0]          grid_now
);

    localparam logic [GRID_W-1:0]  GRID_SAT   = '1;
    localparam logic [PRICE_W-1:0] PRICE_MASK = (PRICE_BITS_DEF >= PRICE_W) ? {PRICE_W{1'b1}}
                                                : {PRICE_W{1'b1}} >> (PRICE_W - PRICE_BITS_DEF);

    typedef struct packed {
        logic [SIZE_W-1:0]  bid_size;
        logic [SIZE_W-1:0]  ask_size;
        logic [PRICE_W-1:0] trade_px;
        logic [PRICE_W-1:0] bid;
        logic [PRICE_W-1:0] ask;
        logic [TIME_W-1:0]  stamp;
    } tick_fields_t;

    typedef struct {
        tick_fields_t f;
        logic         ghost;
        logic         run_end;
        logic         cap;
    } emitted_tick_t;

    emitted_tick_t      ticks_due[$];
    logic [GRID_W-1:0]  grid;
    logic [IVAL_W-1:0]  interval;
    logic               seen_tick;
    logic [PRICE_W-1:0] prev_ask;
    logic [PRICE_W-1:0] prev_bid;
    logic [PRICE_W-1:0] prev_last;

    function void fill_gaps(input tick_fields_t tick);
        emitted_tick_t   entry;
        int unsigned     ghosts;
        logic [GRID_W:0] advanced;
        ghosts = 0;
        tick.ask = tick.ask & PRICE_MASK;
        tick.bid = tick.bid & PRICE_MASK;
        tick.trade_px = tick.trade_px & PRICE_MASK;
        if (seen_tick)
        begin
            while (tick.stamp > grid && ghosts < MAX_GHOSTS_DEF)
            begin
                entry.f.stamp = grid[TIME_W-1:0];
                entry.f.ask = prev_ask;
                entry.f.bid = prev_bid;
                entry.f.trade_px = prev_last;
                entry.f.ask_size = '0;
                entry.f.bid_size = '0;
                entry.ghost = 1'b1;
                entry.run_end = 1'b0;
                entry.cap = 1'b0;
                ticks_due.push_back(entry);
                ghosts++;
                advanced = grid + interval;
                grid = (advanced > GRID_SAT) ? GRID_SAT : advanced[GRID_W-1:0];
            end
        end
        entry.f = tick;
        entry.ghost = 1'b0;
        entry.run_end = (ghosts > 0);
        entry.cap = (ghosts >= MAX_GHOSTS_DEF);
        ticks_due.push_back(entry);
        seen_tick = 1'b1;
        prev_ask = tick.ask;
        prev_bid = tick.bid;
        prev_last = tick.trade_px;
    endfunction

    function void check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        emitted_tick_t got;
        emitted_tick_t want;
        if (!rst_n)
        begin
            ticks_due.delete();
            grid = '0;
            interval = '1;
            seen_tick = 1'b0;
            prev_ask = '0;
            prev_bid = '0;
            prev_last = '0;
            mismatches = 0;
            outstanding = 0;
            grid_now = '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_START_TIME)
                    grid = GRID_W'(cfg_data[TIME_W-1:0]);
                else if (cfg_index == REG_GRID_INTERVAL)
                    interval = cfg_data[IVAL_W-1:0];
            end
            if (m_tvalid && m_tready)
            begin
                got.f = m_tdata[FIELDS_W-1:0];
                got.ghost = m_tuser[USER_GHOST];
                got.cap = m_tuser[USER_CAP];
                got.run_end = m_tlast;
                if (ticks_due.size() == 0)
                begin
                    $error("output transaction with no tick pending: tdata %0h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = ticks_due.pop_front();
                    check_field("out_time", 64'(want.f.stamp), 64'(got.f.stamp));
                    check_field("out_ask", 64'(want.f.ask), 64'(got.f.ask));
                    check_field("out_bid", 64'(want.f.bid), 64'(got.f.bid));
                    check_field("out_last_price", 64'(want.f.trade_px), 64'(got.f.trade_px));
                    check_field("out_ask_size", 64'(want.f.ask_size), 64'(got.f.ask_size));
                    check_field("out_bid_size", 64'(want.f.bid_size), 64'(got.f.bid_size));
                    check_field("is_ghost", 64'(want.ghost), 64'(got.ghost));
                    check_field("run_end", 64'(want.run_end), 64'(got.run_end));
                    check_field("cap_hit", 64'(want.cap), 64'(got.cap));
                end
            end
            if (s_tvalid && s_tready)
                fill_gaps(s_tdata[FIELDS_W-1:0]);
            outstanding = ticks_due.size();
            grid_now = grid;
        end
    end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Top of the tick gap filler testbench: clock, reset, tick and register stimulus, output stalls.
// Instantiates tick_gap_filler_core and tgf_checker side by side; depends on tgf_pkg.
module tb;
    import tgf_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int AT_GIVEN       = -1;
    localparam int BEHIND         = -2;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [IVAL_W-1:0] IVAL_MAX = '1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [DATA_W-1:0]     s_tdata = '0;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    wire logic             s_tready;
    wire logic             m_tvalid;
    wire logic [DATA_W-1:0] m_tdata;
    wire logic [USER_W-1:0] m_tuser;
    wire logic             m_tlast;
    wire logic             cfg_ready;

    int                mismatches;
    int                outstanding;
    logic [GRID_W-1:0] grid_now;
    logic [IVAL_W-1:0] cur_ival = IVAL_MAX;
    int                burst_left = 0;
    int                stall_left = 0;
    int                stall_mode = 0;
    logic [15:0]       stall_pattern = '1;
    int                quiet_cycles = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    tick_gap_filler_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tgf_checker u_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .grid_now    (grid_now)
    );

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_left = $urandom_range(20, 200);
            stall_mode = $urandom_range(0, 3);
            stall_pattern = 16'($urandom) | 16'h0001;
        end
        stall_left--;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2:
            begin
                m_tready <= stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            end
            default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function logic [PRICE_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function logic [DATA_W-1:0] pack_tick(input logic [TIME_W-1:0] stamp,
                                          input logic [PRICE_W-1:0] ask, bid, trade_px,
                                          input logic [SIZE_W-1:0] ask_size, bid_size);
        return {{PAD_W{1'b0}}, bid_size, ask_size, trade_px, bid, ask, stamp};
    endfunction

    function logic [DATA_W-1:0] random_tick();
        return pack_tick(TIME_W'(rand64()), rand_word(), rand_word(), rand_word(),
                         rand_word(), rand_word());
    endfunction

    // A positive ghosts value places the tick so that exactly that many ghosts precede it, or the
    // cap if lower or at a zero interval; 0 gives none; BEHIND places it at or before the grid time.
    task send_tick(input int ghosts, input logic [DATA_W-1:0] fields);
        logic [63:0] target;
        logic [63:0] ceiling;
        int          idle;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (idle > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (idle - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        ceiling = (grid_now > TIME_MAX) ? 64'(TIME_MAX) : 64'(grid_now);
        if (ghosts >= 0)
        begin
            if (ghosts == 0)
                target = ceiling;
            else if (cur_ival == 0)
                target = 64'(grid_now) + 64'd1;
            else
                target = 64'(grid_now) + 64'(ghosts) * 64'(cur_ival) - rand64() % 64'(cur_ival);
            if (target > TIME_MAX)
                target = TIME_MAX;
            fields[TIME_W-1:0] = target[TIME_W-1:0];
        end
        else if (ghosts == BEHIND)
        begin
            target = ceiling - rand64() % (ceiling + 64'd1);
            fields[TIME_W-1:0] = target[TIME_W-1:0];
        end
        s_tdata <= fields;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    task drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        burst_left = 0;
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task set_grid(input logic [TIME_W-1:0] start, input logic [IVAL_W-1:0] ival);
        drain();
        write_reg(REG_START_TIME, start);
        write_reg(REG_GRID_INTERVAL, {(CFG_DATA_W - IVAL_W)'(rand64()), ival});
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_ival = ival;
    endtask

    task random_run(input int count);
        repeat (count)
        begin
            int pick;
            pick = $urandom_range(0, 19);
            if (pick < 4)
                send_tick(BEHIND, random_tick());
            else if (pick == 4)
                send_tick(0, random_tick());
            else if (pick == 5)
                send_tick(AT_GIVEN, random_tick());
            else if (pick == 6)
                send_tick($urandom_range(MAX_GHOSTS_DEF, MAX_GHOSTS_DEF + 20), random_tick());
            else
                send_tick($urandom_range(1, 8), random_tick());
            if ($urandom_range(0, 39) == 0)
                drain();
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: the first tick passes even far ahead of the grid.
        send_tick(AT_GIVEN, pack_tick(TIME_MAX, '1, '1, '1, '1, '1));
        send_tick(0, pack_tick('0, '0, '0, '0, '0, '0));
        send_tick(3, random_tick());
        send_tick(BEHIND, random_tick());
        send_tick(AT_GIVEN, pack_tick(TIME_MAX, '0, '1, '0, '1, '0));
        random_run(15);

        set_grid(TIME_MAX, IVAL_MAX);
        send_tick(0, random_tick());
        send_tick(AT_GIVEN, pack_tick(TIME_MAX, '1, '0, '1, '0, '1));
        send_tick(BEHIND, random_tick());
        random_run(10);

        set_grid(TIME_W'(rand64()) >> 4, IVAL_W'(1));
        send_tick(MAX_GHOSTS_DEF - 1, random_tick());
        send_tick(MAX_GHOSTS_DEF, random_tick());
        send_tick(MAX_GHOSTS_DEF + 1, random_tick());
        send_tick(100, random_tick());
        send_tick(1, random_tick());
        random_run(20);

        // Zero interval: every ghost lands on the same grid time until the cap.
        set_grid('0, '0);
        send_tick(1, random_tick());
        send_tick(0, random_tick());
        send_tick(BEHIND, random_tick());
        random_run(8);

        repeat (5)
        begin
            logic [IVAL_W-1:0] ival;
            case ($urandom_range(0, 3))
                0: ival = IVAL_W'($urandom_range(1, 1000));
                1: ival = IVAL_W'(rand64()) >> $urandom_range(20, 40);
                2: ival = IVAL_W'(rand64()) | IVAL_W'(1);
                default: ival = IVAL_MAX;
            endcase
            set_grid(TIME_W'(rand64()) >> $urandom_range(0, 40), ival);
            random_run(40);
        end

        drain();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### tick_gap_filler_core.f
+incdir+design
design/tgf_pkg.sv
design/tgf_dp.sv
design/tgf_ctrl.sv
design/tick_gap_filler_core.sv
design/tgf_checker.sv
dv/tgf_checker.sv
dv/tb.sv
